>>> rtl/tvd_pkg.sv
// Shared types, codes and decode functions for the tagged varint decoder.
// Used by tvd_decode and tagged_varint_decoder; depends on nothing else.
`default_nettype none

package tvd_pkg;

    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 33;
    localparam int KIND_W   = 2;
    localparam int LENGTH_W = 3;
    localparam int GATH_W   = 24;
    localparam int OUT_W    = 40;

    localparam logic [2:0] FORM_C12   = 3'd0;
    localparam logic [2:0] FORM_C20   = 3'd1;
    localparam logic [2:0] FORM_C28   = 3'd2;
    localparam logic [2:0] FORM_REG4  = 3'd3;
    localparam logic [2:0] FORM_REG12 = 3'd4;
    localparam logic [2:0] FORM_ARG4  = 3'd5;
    localparam logic [2:0] FORM_LIT   = 3'd6;
    localparam logic [2:0] FORM_C12B  = 3'd7;

    localparam logic [1:0] KIND_CONST = 2'd0;
    localparam logic [1:0] KIND_REG   = 2'd1;
    localparam logic [1:0] KIND_ARG   = 2'd2;
    localparam logic [1:0] KIND_LIT   = 2'd3;

    localparam logic [VALUE_W-1:0] LIT_VALUE = 33'h0_8000_0000;

    typedef struct packed {
        logic [LENGTH_W-1:0]       length;
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
    } t_result;

    function automatic logic [1:0] follow_count(input logic [2:0] form);
        logic [1:0] cnt;
        unique case (form)
            FORM_C12, FORM_REG12, FORM_C12B: cnt = 2'd1;
            FORM_C20:                        cnt = 2'd2;
            FORM_C28:                        cnt = 2'd3;
            default:                         cnt = 2'd0;
        endcase
        return cnt;
    endfunction

    function automatic t_result finish(input logic [2:0]        form,
                                       input logic [3:0]        nib,
                                       input logic [GATH_W-1:0] g);
        t_result res;
        unique case (form)
            FORM_C20: begin
                res.value  = {{13{nib[3]}}, nib, g[15:0]};
                res.kind   = KIND_CONST;
                res.length = 3'd3;
            end
            FORM_C28: begin
                res.value  = {{5{nib[3]}}, nib, g};
                res.kind   = KIND_CONST;
                res.length = 3'd4;
            end
            FORM_REG4: begin
                res.value  = {29'd0, nib};
                res.kind   = KIND_REG;
                res.length = 3'd1;
            end
            FORM_REG12: begin
                res.value  = {21'd0, nib, g[7:0]};
                res.kind   = KIND_REG;
                res.length = 3'd2;
            end
            FORM_ARG4: begin
                res.value  = {29'd0, nib};
                res.kind   = KIND_ARG;
                res.length = 3'd1;
            end
            FORM_LIT: begin
                res.value  = LIT_VALUE;
                res.kind   = KIND_LIT;
                res.length = 3'd1;
            end
            default: begin
                res.value  = {{21{nib[3]}}, nib, g[7:0]};
                res.kind   = KIND_CONST;
                res.length = 3'd2;
            end
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tvd_decode.sv
// Decode state (bytes left, form, tag nibble, gathered bytes) and the
// single-byte update that yields a result. Depends on tvd_pkg.
`default_nettype none

module tvd_decode (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [tvd_pkg::BYTE_W-1:0]  i_byte,
    output logic                             o_res_valid,
    output tvd_pkg::t_result                 o_res
);

    logic [1:0]                   r_bytes_left, n_bytes_left;
    logic [2:0]                   r_form,       n_form;
    logic [3:0]                   r_nib,        n_nib;
    logic [tvd_pkg::GATH_W-1:0]   r_gath,       n_gath;
    logic [1:0]                   idx;

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_form       = r_form;
        n_nib        = r_nib;
        n_gath       = r_gath;
        o_res_valid  = 1'b0;
        o_res        = tvd_pkg::finish(r_form, r_nib, r_gath);
        idx          = tvd_pkg::follow_count(r_form) - r_bytes_left;
        if (idx > 2'd2) begin
            idx = 2'd2;
        end
        if (r_bytes_left == 2'd0) begin
            if (!i_byte[7]) begin
                o_res_valid  = 1'b1;
                o_res.value  = {25'd0, i_byte};
                o_res.kind   = tvd_pkg::KIND_CONST;
                o_res.length = 3'd1;
            end else begin
                n_form       = i_byte[6:4];
                n_nib        = i_byte[3:0];
                n_gath       = '0;
                n_bytes_left = tvd_pkg::follow_count(i_byte[6:4]);
                if (n_bytes_left == 2'd0) begin
                    o_res_valid = 1'b1;
                    o_res       = tvd_pkg::finish(n_form, n_nib, n_gath);
                end
            end
        end else begin
            n_gath       = r_gath | (tvd_pkg::GATH_W'(i_byte) << {idx, 3'b000});
            n_bytes_left = r_bytes_left - 2'd1;
            if (n_bytes_left == 2'd0) begin
                o_res_valid = 1'b1;
                o_res       = tvd_pkg::finish(r_form, r_nib, n_gath);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_form       <= '0;
            r_nib        <= '0;
            r_gath       <= '0;
        end else if (i_step) begin
            r_bytes_left <= n_bytes_left;
            r_form       <= n_form;
            r_nib        <= n_nib;
            r_gath       <= n_gath;
        end
    end

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_bytes_left != 2'd0) |=> r_bytes_left == $past(r_bytes_left) - 2'd1)
        else $error("bytes left did not count down");

    a_done_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> n_bytes_left == 2'd0)
        else $error("result given with bytes still pending");

    a_lit_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == tvd_pkg::KIND_LIT) |->
            o_res.value == tvd_pkg::LIT_VALUE)
        else $error("special literal has wrong value");

    a_long_is_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.length == 3'd3 || o_res.length == 3'd4)) |->
            o_res.kind == tvd_pkg::KIND_CONST)
        else $error("long form is not a constant");

endmodule

`default_nettype wire

>>> rtl/tagged_varint_decoder.sv
// Top level of the tagged varint decoder: input register, decode stage and
// result register with stream handshakes. Depends on tvd_pkg and tvd_decode.
// Accepts one byte per cycle while the output is not stalled; the last byte of
// a number passes the input register, then its result the result register.
// Bytes that do not finish a number produce no output request.
`default_nettype none

module tagged_varint_decoder (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [7:0] byte_in
    input  wire logic [tvd_pkg::BYTE_W-1:0] i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    // [32:0] value, [34:33] kind, [37:35] length, [39:38] zero
    output logic [tvd_pkg::OUT_W-1:0]       o_m_axis_tdata
);

    logic                          r_in_valid;
    logic [tvd_pkg::BYTE_W-1:0]    r_in_byte;
    logic                          r_out_valid;
    tvd_pkg::t_result              r_out;
    logic                          out_ready;
    logic                          step;
    logic                          res_valid;
    tvd_pkg::t_result              res;

    assign out_ready       = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && out_ready;
    assign o_s_axis_tready = !r_in_valid || out_ready;

    tvd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> r_out_valid && $stable(r_out))
        else $error("pending result changed while stalled");

    a_step_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> out_ready)
        else $error("decode advanced with result register full");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_ready) |=> r_in_valid && $stable(r_in_byte))
        else $error("input register lost a byte");

endmodule

`default_nettype wire
